[src/lba_pkg.sv]
`default_nettype none
package lba_pkg;

    localparam int unsigned NUM_BLOCKS_DEF = 1024;
    localparam logic [15:0] LEASE_RESET    = 16'd600;
    localparam int unsigned EXP_W          = 32;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_TOUCH = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_BUSY = 2'd1,
        ST_NO_FREE  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_WRITE
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [30:0] timestamp;
        logic [10:0] touch_blk;
    } t_in;

    typedef struct packed {
        logic [10:0] granted_block;
        t_status     status;
    } t_out;

endpackage
`default_nettype wire

[src/lba_ram.sv]
`default_nettype none
module lba_ram #(
    parameter int unsigned DEPTH = lba_pkg::NUM_BLOCKS_DEF,
    parameter int unsigned DW    = lba_pkg::EXP_W + 1,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[src/lease_block_allocator_unit.sv]
// A new request is taken only in the idle state, after the last one is done;
// every request walks the whole lease store through its single read port,
// one entry per cycle.
// Reset (synchronous, active low): a clearing pass marks every block free
// before the first request is taken; lease length resets to 600.
// A finished result waits in the output register while the next request runs.
`default_nettype none
module lease_block_allocator_unit #(
    parameter int unsigned NUM_BLOCKS = lba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire lba_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output lba_pkg::t_out     o_data,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata
);

    localparam int unsigned AW = $clog2(NUM_BLOCKS);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned DW = lba_pkg::EXP_W + 1;
    localparam logic [CW-1:0] CNT_END  = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_BLOCKS - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(NUM_BLOCKS - 1);

    lba_pkg::t_state r_state, n_state;

    logic [15:0]   r_lease;
    logic [CW-1:0] r_cnt;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    lba_pkg::t_func r_func;
    logic [30:0]   r_now;
    logic [31:0]   r_until;
    logic [AW-1:0] r_tidx;
    logic          r_blk_ok;
    logic          r_found;
    logic [AW-1:0] r_free;
    logic          r_tbusy;
    logic          r_ovalid;
    lba_pkg::t_out r_odata;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    logic          accept, out_free, commit;
    logic          rd_busy, rd_expired, swept_busy;
    logic [31:0]   rd_exp;
    logic [31:0]   blk_ext, blk_m1, free_num;
    lba_pkg::t_out result;

    lba_ram #(
        .DEPTH(NUM_BLOCKS),
        .DW   (DW),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign accept     = i_valid && o_ready;
    assign out_free   = !r_ovalid || i_ready;
    assign rd_busy    = mem_rdata[DW-1];
    assign rd_exp     = mem_rdata[31:0];
    assign rd_expired = rd_exp <= {1'b0, r_now};
    assign swept_busy = rd_busy && !rd_expired;
    assign blk_ext    = {21'd0, i_data.touch_blk};
    assign blk_m1     = blk_ext - 32'd1;
    assign free_num   = 32'(r_free) + 32'd1;
    assign commit     = (r_func == lba_pkg::FUNC_ALLOC) ? r_found : (r_blk_ok && r_tbusy);

    always_comb begin
        result.granted_block = 11'd0;
        result.status        = lba_pkg::ST_OK;
        if (r_func == lba_pkg::FUNC_ALLOC) begin
            if (r_found) begin
                result.granted_block = free_num[10:0];
            end else begin
                result.status = lba_pkg::ST_NO_FREE;
            end
        end else if (!(r_blk_ok && r_tbusy)) begin
            result.status = lba_pkg::ST_NOT_BUSY;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lba_pkg::S_CLEAR: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = lba_pkg::S_IDLE;
                end
            end
            lba_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = lba_pkg::S_SWEEP;
                end
            end
            lba_pkg::S_SWEEP: begin
                if (r_pv && r_pidx == IDX_LAST) begin
                    n_state = lba_pkg::S_WRITE;
                end
            end
            lba_pkg::S_WRITE: begin
                if (out_free) begin
                    n_state = lba_pkg::S_IDLE;
                end
            end
            default: n_state = lba_pkg::S_IDLE;
        endcase
    end

    // memory control and handshake outputs
    always_comb begin
        o_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_cnt[AW-1:0];
        unique case (r_state)
            lba_pkg::S_CLEAR: begin
                mem_we = 1'b1;
            end
            lba_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            lba_pkg::S_SWEEP: begin
                mem_re = r_cnt < CNT_END;
                // free an expired lease; the read runs one entry ahead
                if (r_pv && rd_busy && rd_expired) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx;
                    mem_wdata = {1'b0, rd_exp};
                end
            end
            lba_pkg::S_WRITE: begin
                if (out_free && commit) begin
                    mem_we    = 1'b1;
                    mem_waddr = (r_func == lba_pkg::FUNC_ALLOC) ? r_free : r_tidx;
                    mem_wdata = {1'b1, r_until};
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lba_pkg::S_CLEAR;
            r_lease  <= lba_pkg::LEASE_RESET;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lease <= i_cfg_wdata;
            end
            if (r_state == lba_pkg::S_CLEAR) begin
                r_cnt <= (r_cnt == CNT_LAST) ? '0 : r_cnt + CW'(1);
            end else if (accept) begin
                r_cnt <= '0;
            end else if (mem_re) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_pv <= mem_re;
            if (r_state == lba_pkg::S_WRITE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= mem_raddr;
        if (accept) begin
            r_func   <= i_data.func;
            r_now    <= i_data.timestamp;
            r_until  <= {1'b0, i_data.timestamp} + {16'd0, r_lease};
            r_tidx   <= blk_m1[AW-1:0];
            r_blk_ok <= (blk_ext != 32'd0) && (blk_ext <= 32'(NUM_BLOCKS));
            r_found  <= 1'b0;
            r_tbusy  <= 1'b0;
        end else if (r_state == lba_pkg::S_SWEEP && r_pv) begin
            if (!swept_busy && !r_found) begin
                r_found <= 1'b1;
                r_free  <= r_pidx;
            end
            if (r_pidx == r_tidx) begin
                r_tbusy <= swept_busy;
            end
        end
        if (r_state == lba_pkg::S_WRITE && out_free) begin
            r_odata <= result;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same entry in one cycle");

    a_accept_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == lba_pkg::S_SWEEP))
        else $error("accepted transaction did not start a sweep");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == lba_pkg::S_WRITE))
        else $error("result appeared outside the write step");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != lba_pkg::ST_OK) |-> (o_data.granted_block == 11'd0))
        else $error("failed transaction carries a block number");

endmodule
`default_nettype wire
